FILE: rtl/ralc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region allocator package
// Status and operation codes and the fixed port widths of the allocator.
// ----------------------------------------------------------------------------
package ralc_pkg;

    localparam int MODE_W   = 3;
    localparam int ADDR_W   = 32;
    localparam int ALIGN_W  = 5;
    localparam int OWNER_W  = 8;
    localparam int STATUS_W = 4;
    localparam int COUNT_W  = 6;

    typedef logic [MODE_W-1:0]   t_mode;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_mode MODE_ADD        = 3'd0;
    localparam t_mode MODE_ALLOC      = 3'd1;
    localparam t_mode MODE_ALLOC_HINT = 3'd2;
    localparam t_mode MODE_FREE       = 3'd3;
    localparam t_mode MODE_FREE_OWNER = 3'd4;
    localparam t_mode MODE_QUERY      = 3'd5;

    localparam t_status ST_OK       = 4'd0;
    localparam t_status ST_NOSPACE  = 4'd1;
    localparam t_status ST_OVERLAP  = 4'd2;
    localparam t_status ST_NOTALLOC = 4'd3;
    localparam t_status ST_NOTOWNED = 4'd4;
    localparam t_status ST_FULL     = 4'd5;
    localparam t_status ST_AVAIL    = 4'd6;
    localparam t_status ST_UNAVAIL  = 4'd7;
    localparam t_status ST_INUSE    = 4'd8;
    localparam t_status ST_OVERFLOW = 4'd9;

    localparam logic [COUNT_W-1:0] FREED_MAX = 6'd63;

endpackage

FILE: rtl/region_allocator_free_list_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region allocator with coalescing free list
// Sorted free table and used table in synchronous memories, run by a
// sequencer that scans, shifts and rewrites entries.
// ----------------------------------------------------------------------------
// One operation at a time. Every table visit goes through a registered memory
// read, so a scan visits the free entries and the used entries in turn, and
// inserting or removing a free entry shifts the tail of the free table entry
// by entry; finding a used slot checks the valid bits in turn, the first-fit
// pass tries the free entries in turn, and free-owner repeats a free-table
// pass per released slot.
// The result is held in an output register, so a new beat is taken while the
// previous result waits. No clearing pass is needed after reset.
module region_allocator_free_list_unit #(
    parameter int FREE_ENTRIES = 32,
    parameter int USED_ENTRIES = 32,
    parameter int ADDR_BITS    = 32,
    parameter int OWNER_BITS   = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ralc_pkg::MODE_W-1:0]   i_mode,
    input  logic [ralc_pkg::ADDR_W-1:0]   i_start_address,
    input  logic [ralc_pkg::ADDR_W-1:0]   i_region_size,
    input  logic [ralc_pkg::ALIGN_W-1:0]  i_alignment_log2,
    input  logic [ralc_pkg::OWNER_W-1:0]  i_owner_id,
    input  logic [ralc_pkg::ADDR_W-1:0]   i_hint_address,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ralc_pkg::STATUS_W-1:0] o_status,
    output logic [ralc_pkg::ADDR_W-1:0]   o_granted_start,
    output logic [ralc_pkg::OWNER_W-1:0]  o_holder_id,
    output logic [ralc_pkg::COUNT_W-1:0]  o_freed_count
);
    import ralc_pkg::*;

    localparam int AW = ADDR_BITS;
    localparam int OB = OWNER_BITS;
    localparam int FI = $clog2(FREE_ENTRIES);
    localparam int FC = $clog2(FREE_ENTRIES + 1);
    localparam int UI = $clog2(USED_ENTRIES);
    localparam int UC = $clog2(USED_ENTRIES + 1);
    localparam logic [AW-1:0] MASK = {AW{1'b1}};

    typedef enum logic [4:0] {
        S_IDLE, S_DONE,
        S_INS_GO, S_INS_RD, S_INS_CHK, S_INS_DEC, S_INS_RET,
        S_OG_RD, S_OG_WR, S_CG_GO, S_CG_RD, S_CG_WR, S_FWR, S_HEADWR,
        S_SLOT, S_HINT_RD, S_HINT_CHK, S_FF_RD, S_TRY_A, S_TRY_B, S_USE_WR,
        S_U_RD, S_U_CHK, S_Q_RD, S_Q_CHK
    } t_state;

    t_state r_state, r_ret;

    t_mode          r_mode;
    logic [AW-1:0]  r_start, r_size, r_hint;
    logic [4:0]     r_lg;
    logic [OB-1:0]  r_owner;
    logic           r_alloc, r_hint_phase;

    t_status        r_st, r_ist;
    logic [AW-1:0]  r_granted;
    logic [OB-1:0]  r_holder;
    logic [COUNT_W-1:0] r_freed;

    logic [FC-1:0]  r_cnt, r_fk, r_idx, r_i;
    logic [UC-1:0]  r_uk, r_slot;
    logic           r_valid [USED_ENTRIES];

    // insert working set
    logic [AW-1:0]  r_is, r_in;
    logic           r_pv, r_nv;
    logic [AW-1:0]  r_ps, r_pl, r_nl;
    logic [AW-1:0]  r_ns;

    // allocation working set
    logic [AW-1:0]  r_es, r_el, r_s, r_head;
    logic           r_afail;

    // pending single free-table write
    logic [FC-1:0]  r_wa;
    logic [AW-1:0]  r_ws, r_wl;

    logic           r_ovalid;
    t_status        r_ost;
    logic [AW-1:0]  r_ogranted;
    logic [OB-1:0]  r_oholder;
    logic [COUNT_W-1:0] r_ofreed;

    // memories
    logic              f_we;
    logic [FI-1:0]     f_waddr;
    logic [2*AW-1:0]   f_wdata, f_q;
    logic              u_we;
    logic [2*AW+OB-1:0] u_wdata, u_q;

    logic [AW-1:0] fq_start, fq_len, uq_start, uq_len;
    logic [OB-1:0] uq_holder;

    assign fq_start  = f_q[2*AW-1:AW];
    assign fq_len    = f_q[AW-1:0];
    assign uq_start  = u_q[2*AW+OB-1:AW+OB];
    assign uq_len    = u_q[AW+OB-1:OB];
    assign uq_holder = u_q[OB-1:0];

    ralc_ram #(.DEPTH(FREE_ENTRIES), .WIDTH(2*AW)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (r_fk[FI-1:0]),
        .o_rdata (f_q)
    );

    ralc_ram #(.DEPTH(USED_ENTRIES), .WIDTH(2*AW+OB)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (r_slot[UI-1:0]),
        .i_wdata (u_wdata),
        .i_raddr (r_uk[UI-1:0]),
        .o_rdata (u_q)
    );

    always_comb begin
        f_we    = 1'b0;
        f_waddr = r_wa[FI-1:0];
        f_wdata = {r_ws, r_wl};
        unique case (r_state)
            S_FWR: begin
                f_we = 1'b1;
            end
            S_HEADWR: begin
                f_we    = 1'b1;
                f_waddr = r_i[FI-1:0];
                f_wdata = {r_es, r_head};
            end
            S_OG_WR: begin
                f_we    = 1'b1;
                f_waddr = FI'(r_fk + FC'(1));
                f_wdata = f_q;
            end
            S_CG_WR: begin
                f_we    = 1'b1;
                f_waddr = FI'(r_fk - FC'(1));
                f_wdata = f_q;
            end
            default: begin
            end
        endcase
    end

    assign u_we    = (r_state == S_USE_WR);
    assign u_wdata = {r_s, r_size, r_owner};

    // input conversion
    logic [AW-1:0] w_start, w_size, w_hint;
    assign w_start = AW'(i_start_address);
    assign w_size  = AW'(i_region_size);
    assign w_hint  = AW'(i_hint_address);

    // insert scan terms
    logic [AW-1:0] w_ins_end, w_fq_end;
    assign w_ins_end = r_is + r_in;
    assign w_fq_end  = fq_start + fq_len;

    // aligned candidate start
    logic [AW-1:0] w_x, w_am, w_low, w_base;
    logic [AW:0]   w_one, w_sum;
    logic          w_big;
    assign w_x    = r_hint_phase ? r_hint : fq_start;
    assign w_am   = ~(MASK << r_lg);
    assign w_low  = w_x & w_am;
    assign w_base = w_x & ~w_am;
    assign w_one  = (AW+1)'(1) << r_lg;
    assign w_sum  = {1'b0, w_base} + w_one;
    assign w_big  = (int'(r_lg) >= AW);

    // fit check
    logic [AW-1:0] w_re, w_rem, w_head, w_tail, w_send;
    logic          w_fail;
    assign w_re   = r_es + r_el;
    assign w_rem  = w_re - r_s;
    assign w_fail = r_afail || (r_s > w_re) || (r_size > w_rem);
    assign w_head = r_s - r_es;
    assign w_tail = w_rem - r_size;
    assign w_send = r_s + r_size;

    // query terms
    logic [AW-1:0] w_q_end, w_u_end;
    assign w_q_end = r_start + r_size;
    assign w_u_end = uq_start + uq_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_hint   <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < USED_ENTRIES; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else begin
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mode       <= i_mode;
                        r_start      <= w_start;
                        r_size       <= w_size;
                        r_lg         <= i_alignment_log2;
                        r_owner      <= OB'(i_owner_id);
                        r_st         <= ST_OK;
                        r_granted    <= '0;
                        r_holder     <= '0;
                        r_freed      <= '0;
                        r_uk         <= '0;
                        r_fk         <= '0;
                        r_alloc      <= (i_mode == MODE_ALLOC) || (i_mode == MODE_ALLOC_HINT);
                        r_hint_phase <= 1'b0;
                        r_is         <= w_start;
                        r_in         <= w_size;
                        priority case (i_mode)
                            MODE_ADD: begin
                                if (w_size > MASK - w_start) begin
                                    r_st    <= ST_OVERFLOW;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_INS_GO;
                                end
                            end
                            MODE_ALLOC: begin
                                r_state <= S_SLOT;
                            end
                            MODE_ALLOC_HINT: begin
                                r_hint  <= w_hint;
                                r_state <= S_SLOT;
                            end
                            MODE_FREE, MODE_FREE_OWNER: begin
                                r_state <= S_U_RD;
                            end
                            MODE_QUERY: begin
                                if (w_size > MASK - w_start) begin
                                    r_st    <= ST_OVERFLOW;
                                    r_state <= S_DONE;
                                end else begin
                                    r_st    <= ST_UNAVAIL;
                                    r_state <= S_U_RD;
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end

                S_DONE: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_ovalid   <= 1'b1;
                        r_ost      <= r_st;
                        r_ogranted <= (r_st == ST_OK) ? r_granted : '0;
                        r_oholder  <= r_holder;
                        r_ofreed   <= r_freed;
                        r_state    <= S_IDLE;
                    end
                end

                // ---------------- insert into the free table ----------------
                S_INS_GO: begin
                    r_ist <= ST_OK;
                    r_fk  <= '0;
                    r_idx <= '0;
                    r_pv  <= 1'b0;
                    r_nv  <= 1'b0;
                    r_state <= (r_in == '0) ? S_INS_RET : S_INS_RD;
                end
                S_INS_RD: begin
                    r_state <= (r_fk == r_cnt) ? S_INS_DEC : S_INS_CHK;
                end
                S_INS_CHK: begin
                    if (r_is < w_fq_end && w_ins_end > fq_start) begin
                        r_ist   <= ST_OVERLAP;
                        r_state <= S_INS_RET;
                    end else begin
                        if (fq_start < r_is) begin
                            r_pv  <= 1'b1;
                            r_ps  <= fq_start;
                            r_pl  <= fq_len;
                            r_idx <= r_fk + FC'(1);
                        end else if (!r_nv) begin
                            r_nv <= 1'b1;
                            r_ns <= fq_start;
                            r_nl <= fq_len;
                        end
                        r_fk    <= r_fk + FC'(1);
                        r_state <= S_INS_RD;
                    end
                end
                S_INS_DEC: begin
                    if (r_pv && (r_ps + r_pl == r_is) && r_nv && (r_ns == w_ins_end)) begin
                        r_wa    <= r_idx - FC'(1);
                        r_ws    <= r_ps;
                        r_wl    <= r_pl + r_in + r_nl;
                        r_fk    <= r_idx + FC'(1);
                        r_ret   <= S_CG_GO;
                        r_state <= S_FWR;
                    end else if (r_pv && (r_ps + r_pl == r_is)) begin
                        r_wa    <= r_idx - FC'(1);
                        r_ws    <= r_ps;
                        r_wl    <= r_pl + r_in;
                        r_ret   <= S_INS_RET;
                        r_state <= S_FWR;
                    end else if (r_nv && (r_ns == w_ins_end)) begin
                        r_wa    <= r_idx;
                        r_ws    <= r_is;
                        r_wl    <= r_nl + r_in;
                        r_ret   <= S_INS_RET;
                        r_state <= S_FWR;
                    end else if (r_cnt >= FC'(FREE_ENTRIES)) begin
                        r_ist   <= ST_FULL;
                        r_state <= S_INS_RET;
                    end else begin
                        r_wa    <= r_idx;
                        r_ws    <= r_is;
                        r_wl    <= r_in;
                        r_ret   <= S_INS_RET;
                        r_i     <= r_idx;
                        r_cnt   <= r_cnt + FC'(1);
                        r_fk    <= r_cnt - FC'(1);
                        r_state <= (r_cnt > r_idx) ? S_OG_RD : S_FWR;
                    end
                end
                S_INS_RET: begin
                    priority case (r_mode)
                        MODE_FREE: begin
                            if (r_ist != ST_FULL) begin
                                r_valid[r_uk[UI-1:0]] <= 1'b0;
                            end
                            r_st    <= r_ist;
                            r_state <= S_DONE;
                        end
                        MODE_FREE_OWNER: begin
                            if (r_ist != ST_FULL) begin
                                r_valid[r_uk[UI-1:0]] <= 1'b0;
                                if (r_freed != FREED_MAX) begin
                                    r_freed <= r_freed + COUNT_W'(1);
                                end
                            end
                            if (r_ist != ST_OK && r_st == ST_OK) begin
                                r_st <= r_ist;
                            end
                            r_uk    <= r_uk + UC'(1);
                            r_state <= S_U_RD;
                        end
                        default: begin
                            r_st    <= r_ist;
                            r_state <= S_DONE;
                        end
                    endcase
                end

                // ---------------- free-table shifts and writes ----------------
                // r_wa holds the slot being opened; entries at and above it move up.
                S_OG_RD: begin
                    r_state <= S_OG_WR;
                end
                S_OG_WR: begin
                    if (r_fk == r_wa) begin
                        r_state <= S_FWR;
                    end else begin
                        r_fk    <= r_fk - FC'(1);
                        r_state <= S_OG_RD;
                    end
                end
                S_CG_GO: begin
                    if (r_fk < r_cnt) begin
                        r_state <= S_CG_RD;
                    end else begin
                        r_cnt   <= r_cnt - FC'(1);
                        r_state <= r_alloc ? S_USE_WR : S_INS_RET;
                    end
                end
                S_CG_RD: begin
                    r_state <= S_CG_WR;
                end
                S_CG_WR: begin
                    r_fk    <= r_fk + FC'(1);
                    r_state <= S_CG_GO;
                end
                S_FWR: begin
                    r_state <= r_ret;
                end
                S_HEADWR: begin
                    r_state <= S_USE_WR;
                end

                // ---------------- allocation ----------------
                S_SLOT: begin
                    if (r_uk == UC'(USED_ENTRIES)) begin
                        r_st    <= ST_FULL;
                        r_state <= S_DONE;
                    end else if (!r_valid[r_uk[UI-1:0]]) begin
                        r_slot  <= r_uk;
                        r_fk    <= '0;
                        r_state <= S_HINT_RD;
                    end else begin
                        r_uk <= r_uk + UC'(1);
                    end
                end
                S_HINT_RD: begin
                    if (r_fk == r_cnt) begin
                        r_fk    <= '0;
                        r_state <= S_FF_RD;
                    end else begin
                        r_state <= S_HINT_CHK;
                    end
                end
                S_HINT_CHK: begin
                    if (fq_start <= r_hint && (r_hint - fq_start) < fq_len) begin
                        r_hint_phase <= 1'b1;
                        r_state      <= S_TRY_A;
                    end else begin
                        r_fk    <= r_fk + FC'(1);
                        r_state <= S_HINT_RD;
                    end
                end
                S_FF_RD: begin
                    if (r_fk == r_cnt) begin
                        r_st    <= ST_NOSPACE;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_TRY_A;
                    end
                end
                S_TRY_A: begin
                    r_es    <= fq_start;
                    r_el    <= fq_len;
                    r_afail <= (w_low != '0) && (w_big || w_sum[AW]);
                    r_s     <= (w_low != '0) ? w_sum[AW-1:0] : w_x;
                    r_state <= S_TRY_B;
                end
                S_TRY_B: begin
                    r_i    <= r_fk;
                    r_head <= w_head;
                    if (w_fail) begin
                        if (r_hint_phase) begin
                            r_hint_phase <= 1'b0;
                            r_fk         <= '0;
                        end else begin
                            r_fk <= r_fk + FC'(1);
                        end
                        r_state <= S_FF_RD;
                    end else if (w_head != '0 && w_tail != '0) begin
                        if (r_cnt >= FC'(FREE_ENTRIES)) begin
                            r_st    <= ST_FULL;
                            r_state <= S_DONE;
                        end else begin
                            // split in two: the tail takes a new entry after this one
                            r_wa    <= r_fk + FC'(1);
                            r_ws    <= w_send;
                            r_wl    <= w_tail;
                            r_ret   <= S_HEADWR;
                            r_cnt   <= r_cnt + FC'(1);
                            r_fk    <= r_cnt - FC'(1);
                            r_state <= (r_cnt > r_fk + FC'(1)) ? S_OG_RD : S_FWR;
                        end
                    end else if (w_head != '0) begin
                        r_state <= S_HEADWR;
                    end else if (w_tail != '0) begin
                        r_wa    <= r_fk;
                        r_ws    <= w_send;
                        r_wl    <= w_tail;
                        r_ret   <= S_USE_WR;
                        r_state <= S_FWR;
                    end else begin
                        r_fk    <= r_fk + FC'(1);
                        r_state <= S_CG_GO;
                    end
                end
                S_USE_WR: begin
                    r_valid[r_slot[UI-1:0]] <= 1'b1;
                    r_hint    <= r_s + r_size;
                    r_granted <= r_s;
                    r_st      <= ST_OK;
                    r_state   <= S_DONE;
                end

                // ---------------- used-table scans ----------------
                S_U_RD: begin
                    if (r_uk == UC'(USED_ENTRIES)) begin
                        priority case (r_mode)
                            MODE_FREE: begin
                                r_st    <= ST_NOTALLOC;
                                r_state <= S_DONE;
                            end
                            MODE_QUERY: begin
                                r_fk    <= '0;
                                r_state <= S_Q_RD;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end else begin
                        r_state <= S_U_CHK;
                    end
                end
                S_U_CHK: begin
                    r_is <= uq_start;
                    r_in <= uq_len;
                    r_state <= S_U_RD;
                    priority case (r_mode)
                        MODE_FREE: begin
                            if (r_valid[r_uk[UI-1:0]] && uq_start == r_start) begin
                                if (uq_holder == r_owner) begin
                                    r_state <= S_INS_GO;
                                end else begin
                                    r_st    <= ST_NOTOWNED;
                                    r_state <= S_DONE;
                                end
                            end else begin
                                r_uk <= r_uk + UC'(1);
                            end
                        end
                        MODE_FREE_OWNER: begin
                            if (r_valid[r_uk[UI-1:0]] && uq_holder == r_owner) begin
                                r_state <= S_INS_GO;
                            end else begin
                                r_uk <= r_uk + UC'(1);
                            end
                        end
                        default: begin
                            if (r_valid[r_uk[UI-1:0]] && r_start < w_u_end
                                && w_q_end > uq_start) begin
                                r_st     <= ST_INUSE;
                                r_holder <= uq_holder;
                                r_state  <= S_DONE;
                            end else begin
                                r_uk <= r_uk + UC'(1);
                            end
                        end
                    endcase
                end
                S_Q_RD: begin
                    r_state <= (r_fk == r_cnt) ? S_DONE : S_Q_CHK;
                end
                S_Q_CHK: begin
                    if (r_start >= fq_start && w_q_end <= w_fq_end) begin
                        r_st    <= ST_AVAIL;
                        r_state <= S_DONE;
                    end else begin
                        r_fk    <= r_fk + FC'(1);
                        r_state <= S_Q_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_ovalid;
    assign o_status        = r_ost;
    assign o_granted_start = ADDR_W'(r_ogranted);
    assign o_holder_id     = OWNER_W'(r_oholder);
    assign o_freed_count   = r_ofreed;
endmodule

FILE: rtl/ralc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region allocator table memory
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module ralc_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule
